### design/tadpcm_pkg.sv
// Shared types and constants for the table-driven ADPCM byte decoder.
// Holds the slope ROM, field widths and the queue head struct; no dependencies.
package tadpcm_pkg;

    localparam int CodeW      = 8;
    localparam int NibbleW    = 4;
    localparam int SampleW    = 8;
    localparam int RowW       = 6;
    localparam int RomDepth   = 64;
    localparam int RomW       = 16;
    localparam int QueueDepthDefault = 2;

    localparam logic [SampleW-1:0] SampleMax = 8'hff;

    // Slope ROM: high byte is the step size, low bits the next row offset
    localparam logic [RomW-1:0] SlopeRom [RomDepth] = '{
        16'h0000, 16'h0100, 16'h0200, 16'h0400, 16'h0610, 16'h0810, 16'h0C18, 16'h1020,
        16'h0100, 16'h0300, 16'h0508, 16'h0908, 16'h0D18, 16'h1118, 16'h1920, 16'h2128,
        16'h0208, 16'h0508, 16'h0810, 16'h0E10, 16'h1420, 16'h1A20, 16'h2628, 16'h3230,
        16'h0310, 16'h0710, 16'h0B18, 16'h1318, 16'h1B28, 16'h2328, 16'h2930, 16'h4338,
        16'h0418, 16'h0918, 16'h0E20, 16'h1820, 16'h2230, 16'h2C30, 16'h4038, 16'h5438,
        16'h0520, 16'h0B20, 16'h1128, 16'h1D28, 16'h2938, 16'h3538, 16'h4D38, 16'h6F38,
        16'h0628, 16'h0D28, 16'h1430, 16'h2230, 16'h3038, 16'h3E38, 16'h5A38, 16'h7638,
        16'h0730, 16'h0F30, 16'h1738, 16'h2738, 16'h3738, 16'h4738, 16'h6738, 16'h7D38
    };

    // Head of the byte queue as seen by the decode side
    typedef struct packed {
        logic             valid;
        logic [CodeW-1:0] code_byte;
    } tadpcm_head_t;

endpackage

### design/tadpcm_front.sv
// Front end: accepts code bytes from the input stream into a short queue.
// Depends on tadpcm_pkg for the head struct and field widths.
module tadpcm_front
    import tadpcm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [CodeW-1:0] s_tdata,      // [7:0] code_byte
    output tadpcm_head_t     head,
    input  logic             pop
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

    logic [CodeW-1:0] queue_mem [QUEUE_DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             push;
    logic             do_pop;

    assign s_tready = (count_reg != DepthCnt);
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && (count_reg != '0);

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store each transfer in the queue
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= s_tdata;
        end
    end

    assign head.valid     = (count_reg != '0);
    assign head.code_byte = queue_mem[rd_ptr_reg];

endmodule

### design/tadpcm_back.sv
// Back end: decodes the queued byte one nibble per cycle while the output is not stalled,
// through the slope ROM, and holds each sample in the output register. Depends on tadpcm_pkg.
module tadpcm_back
    import tadpcm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  tadpcm_head_t       head,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [SampleW-1:0] m_tdata,   // [7:0] pcm_sample
    output logic               m_tlast    // last_of_pair
);

    logic               phase_reg, phase_next;     // 0: low nibble, 1: high nibble
    logic [SampleW-1:0] level_reg, level_next;
    logic [RowW-1:0]    row_reg, row_next;
    logic               m_valid_reg, m_valid_next;
    logic [SampleW-1:0] pcm_reg;
    logic               last_reg;

    logic               load;
    logic [NibbleW-1:0] nibble;
    logic [RowW-1:0]    rom_idx;
    logic [RomW-1:0]    entry;
    logic [SampleW-1:0] step;
    logic [SampleW:0]   sum;

    assign load   = head.valid && (!m_valid_reg || m_tready);
    assign pop    = load && phase_reg;
    assign nibble = phase_reg ? head.code_byte[7:4] : head.code_byte[3:0];

    // Look up the slope entry and update the running sample
    always_comb begin
        rom_idx    = row_reg | {3'b000, nibble[3:1]};
        entry      = SlopeRom[rom_idx];
        step       = entry[15:8];
        sum        = {1'b0, level_reg} + {1'b0, step};
        level_next = level_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        if (load) begin
            row_next   = entry[RowW-1:0];
            phase_next = ~phase_reg;
            if (nibble[0]) begin
                level_next = (step > level_reg) ? '0 : level_reg - step;
            end else begin
                level_next = sum[SampleW] ? SampleMax : sum[SampleW-1:0];
            end
        end
        m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 1'b0;
            level_reg   <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            level_reg   <= level_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the sample until the output transfer completes
    always_ff @(posedge aclk) begin
        if (load) begin
            pcm_reg  <= level_next;
            last_reg <= phase_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = pcm_reg;
    assign m_tlast  = last_reg;

endmodule

### design/table_adpcm_byte_decoder_top.sv
// Table-driven ADPCM byte decoder: one code byte in, two 8-bit samples out.
// Each code byte is first written into the queue; its low-nibble sample is then registered in the output register.
// One sample per cycle while the output is not stalled; a byte leaves the queue only with its high nibble, from the
// single decode unit that updates the running sample once per nibble.
// Reset (aresetn low, synchronous) empties the queue and clears sample and row.
// Instantiates tadpcm_front and tadpcm_back; depends on tadpcm_pkg.
module table_adpcm_byte_decoder_top
    import tadpcm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CodeW-1:0]   s_tdata,   // [7:0] code_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [SampleW-1:0] m_tdata,   // [7:0] pcm_sample
    output logic               m_tlast    // last_of_pair
);

    tadpcm_head_t head;
    logic         pop;

    // Accept and queue code bytes
    tadpcm_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    // Decode nibbles and drive the result stream
    tadpcm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_pop_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_pop_gives_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid && m_tlast)
        else $error("byte retired without its high-nibble sample");
`endif

endmodule

### tb/sv/table_adpcm_byte_decoder_top_test.sv
// Self-checking testbench for table_adpcm_byte_decoder_top: streams code bytes in,
// predicts both nibble samples per byte and checks every output transfer in order.
// Depends on tadpcm_pkg (widths, slope ROM) and the decoder RTL only.
module table_adpcm_byte_decoder_top_test
    import tadpcm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NumRandomBytes = 1230;
    localparam int  HoldOffCycles  = 300;
    localparam int  HoldOffAfter   = 300;
    localparam int  DrainCycles    = 20;
    localparam time RunLimit       = 5_000_000ns;

    typedef struct packed {
        logic [SampleW-1:0] pcm;
        logic               pair_end;
    } pcm_expect_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [CodeW-1:0]   s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [SampleW-1:0] m_tdata;
    logic               m_tlast;

    // Stimulus and scoreboard storage
    logic [CodeW-1:0] code_byte_q[$];
    pcm_expect_t      pcm_expect_q[$];

    // Predictor state
    logic [SampleW-1:0] level_q = '0;
    logic [RowW-1:0]    row_q   = '0;

    int  err_count  = 0;
    int  bytes_in   = 0;
    bit  byte_taken = 1'b0;
    bit  hold_off   = 1'b0;

    // Sender pacing
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver pacing
    int rx_mode = 0;
    int rx_cnt  = 0;

    table_adpcm_byte_decoder_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] code_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] pcm_sample
        .m_tlast  (m_tlast)    // last_of_pair
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        err_count++;
    endtask

    // Decode one nibble against the slope ROM and advance the running sample
    function automatic logic [SampleW-1:0] decode_nibble(input logic [NibbleW-1:0] nib);
        logic [RowW-1:0]    idx;
        logic [RomW-1:0]    entry;
        logic [SampleW-1:0] step;
        logic [SampleW:0]   sum;
        idx   = row_q | RowW'(nib[NibbleW-1:1]);
        entry = SlopeRom[idx];
        step  = entry[RomW-1:RomW-SampleW];
        row_q = entry[RowW-1:0];
        if (nib[0]) begin
            level_q = (step > level_q) ? '0 : level_q - step;
        end else begin
            sum     = {1'b0, level_q} + {1'b0, step};
            level_q = (sum > {1'b0, SampleMax}) ? SampleMax : sum[SampleW-1:0];
        end
        return level_q;
    endfunction

    // Queue the two samples one code byte produces, low nibble first
    task automatic predict_byte(input logic [CodeW-1:0] code);
        pcm_expect_t e;
        e.pcm      = decode_nibble(code[NibbleW-1:0]);
        e.pair_end = 1'b0;
        pcm_expect_q.push_back(e);
        e.pcm      = decode_nibble(code[CodeW-1:NibbleW]);
        e.pair_end = 1'b1;
        pcm_expect_q.push_back(e);
    endtask

    // Watch input transfers and feed the predictor
    always @(posedge aclk) begin
        byte_taken = aresetn && s_tvalid && s_tready;
        if (byte_taken) begin
            predict_byte(s_tdata);
            bytes_in++;
        end
    end

    // Check each output transfer against the oldest expected sample
    always @(posedge aclk) begin
        pcm_expect_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pcm_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %0d last=%0b", m_tdata, m_tlast));
            end else begin
                e = pcm_expect_q.pop_front();
                if (m_tdata !== e.pcm)
                    report_mismatch($sformatf("pcm_sample got %0d want %0d", m_tdata, e.pcm));
                if (m_tlast !== e.pair_end)
                    report_mismatch($sformatf("last_of_pair got %0b want %0b",
                                              m_tlast, e.pair_end));
            end
        end
    end

    // Drive code bytes in random bursts separated by random gaps
    always @(negedge aclk) begin
        logic             nxt_valid;
        logic [CodeW-1:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (code_byte_q.size() != 0) begin
                nxt_data  = code_byte_q.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    // Stall the output on a randomly chosen pattern, redrawn each time rx_cnt wraps to zero
    always @(negedge aclk) begin
        logic nxt_ready;
        if (rx_cnt == 0)
            rx_mode = $urandom_range(0, 3);
        rx_cnt = (rx_cnt == 49) ? 0 : rx_cnt + 1;
        case (rx_mode)
            0: begin
                nxt_ready = 1'b1;
            end
            1: begin
                nxt_ready = 1'($urandom_range(0, 1));
            end
            2: begin
                nxt_ready = ($urandom_range(0, 3) != 0);
            end
            default: begin
                nxt_ready = (rx_cnt % 3 != 0);
            end
        endcase
        m_tready <= aresetn && !hold_off && nxt_ready;
    end

    // Hold the output off for a long stretch so the input side backs up
    initial begin
        while (bytes_in < HoldOffAfter)
            @(posedge aclk);
        hold_off = 1'b1;
        repeat (HoldOffCycles) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        #(RunLimit);
        $display("Simulation FAILED");
        $finish;
    end

    // Build the stimulus, release reset, then drain and judge
    initial begin
        logic [CodeW-1:0] directed[] = '{
            8'h00, 8'hFF, 8'h0F, 8'hF0,
            8'h10, 8'h32, 8'h54, 8'h76, 8'h98, 8'hBA, 8'hDC, 8'hFE,
            8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hEE,          // climb into the top rail
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,          // fall into the bottom rail
            8'h55, 8'hAA, 8'h01
        };
        logic [CodeW-1:0] run_code;
        int               run_len;
        int               n;

        foreach (directed[i])
            code_byte_q.push_back(directed[i]);

        // Random bytes, with runs of one direction to reach the rails often
        n = 0;
        while (n < NumRandomBytes) begin
            if ($urandom_range(0, 7) == 0) begin
                run_code = {4'($urandom_range(0, 7) * 2 + $urandom_range(0, 1)),
                            4'($urandom_range(0, 7) * 2 + $urandom_range(0, 1))};
                run_code[NibbleW] = run_code[0];
                run_len  = $urandom_range(2, 8);
                repeat (run_len) code_byte_q.push_back(run_code);
                n += run_len;
            end else begin
                code_byte_q.push_back(8'($urandom_range(0, 255)));
                n++;
            end
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (code_byte_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (pcm_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (pcm_expect_q.size() != 0)
            report_mismatch($sformatf("%0d samples never arrived", pcm_expect_q.size()));

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
design/tadpcm_pkg.sv
design/tadpcm_front.sv
design/tadpcm_back.sv
design/table_adpcm_byte_decoder_top.sv
tb/sv/table_adpcm_byte_decoder_top_test.sv
